// File: design/pctd_pkg.sv
// Package for the trial-division prime counter.
// Holds the transaction payload types, the divider control types and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package pctd_pkg;

    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;

    // The smallest divisor that is tried. Values below it are never prime.
    localparam logic [VALUE_BITS-1:0] FIRST_DIVISOR = VALUE_BITS'(2);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  chunk_end;
    } item_t;

    typedef struct packed {
        logic                  prime;
        logic [COUNT_BITS-1:0] prime_count;
        logic                  count_final;
    } result_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

// File: design/prime_count_trial_division.sv
// Top level of the trial-division prime counter: sequencer, chunk counter, result register.
// Depends on pctd_pkg and pctd_divider.
`timescale 1ns / 1ps

// Each input transaction carries a 32-bit unsigned value and a chunk-end mark; each
// produces exactly one result with the prime flag, the saturating count of primes in
// the chunk including this value, and a final flag that copies the chunk-end mark
// (the counter clears after a final result). Values are handled one at a time: the
// input stalls from acceptance until the result is loaded into the output register,
// which can still hold an earlier result that waits to be taken. Divisors 2, 3, 4, ...
// are tried one after another on a single bit-serial divider, so the time that one
// value takes grows with k, the number of divisors tried: k is 0 for values below 2
// and reaches about 65535 for a large prime.

module prime_count_trial_division (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  pctd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output pctd_pkg::result_t result
);

    localparam int VB = pctd_pkg::VALUE_BITS;
    localparam int CB = pctd_pkg::COUNT_BITS;

    pctd_pkg::state_t    state_reg;
    pctd_pkg::state_t    state_next;
    logic [VB-1:0]       value_reg;
    logic [VB-1:0]       value_next;
    logic                last_reg;
    logic                last_next;
    logic [VB-1:0]       d_reg;
    logic [VB-1:0]       d_next;
    logic                prime_reg;
    logic                prime_next;
    logic [CB-1:0]       count_reg;
    logic [CB-1:0]       count_next;
    pctd_pkg::result_t   result_reg;
    pctd_pkg::result_t   result_next;
    logic                result_valid_reg;
    logic                result_valid_next;

    logic                load;
    logic [CB-1:0]       new_count;
    pctd_pkg::div_ctrl_t div_ctrl;
    pctd_pkg::div_stat_t div_stat;
    logic [VB-1:0]       quotient;
    logic [VB-1:0]       remainder;

    pctd_divider #(
        .WIDTH(VB)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (value_reg),
        .divisor   (d_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .stat      (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        d_next         = d_reg;
        prime_next     = prime_reg;
        div_ctrl.start = 1'b0;
        load           = 1'b0;
        case (state_reg)
            pctd_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    value_next = item.value;
                    last_next  = item.chunk_end;
                    d_next     = pctd_pkg::FIRST_DIVISOR;
                    if (item.value < pctd_pkg::FIRST_DIVISOR)
                    begin
                        prime_next = 1'b0;
                        state_next = pctd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = pctd_pkg::ST_START;
                    end
                end
            end
            pctd_pkg::ST_START:
            begin
                div_ctrl.start = 1'b1;
                state_next     = pctd_pkg::ST_DIV;
            end
            pctd_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    // Once the divisor passes the quotient, it has passed the square
                    // root and no factor remains to be found.
                    if (d_reg > quotient)
                    begin
                        prime_next = 1'b1;
                        state_next = pctd_pkg::ST_FINISH;
                    end
                    else if (remainder == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = pctd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = pctd_pkg::ST_START;
                    end
                end
            end
            pctd_pkg::ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load       = 1'b1;
                    state_next = pctd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pctd_pkg::ST_IDLE;
            end
        endcase
    end

    assign new_count = (prime_reg && !(&count_reg)) ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        count_next        = count_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (load)
        begin
            count_next              = last_reg ? '0 : new_count;
            result_next.prime       = prime_reg;
            result_next.prime_count = new_count;
            result_next.count_final = last_reg;
            result_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pctd_pkg::ST_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        last_reg   <= last_next;
        d_reg      <= d_next;
        prime_reg  <= prime_next;
        result_reg <= result_next;
    end

    assign item_stall   = (state_reg != pctd_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An accepted transaction always leaves the sequencer busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg != pctd_pkg::ST_IDLE))
        else $error("sequencer stayed idle after accepting a transaction");

    // The divider is never restarted while a division is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // A finished division is only reported while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == pctd_pkg::ST_DIV))
        else $error("divider result arrived outside the division state");

    // A final result clears the chunk counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_reg) |=> (count_reg == '0))
        else $error("chunk counter not cleared after a final result");

endmodule

// File: design/pctd_divider.sv
// Bit-serial restoring divider: one shift-and-subtract step per cycle.
// Depends on pctd_pkg for the control and status structs.
`timescale 1ns / 1ps

module pctd_divider #(
    parameter int WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pctd_pkg::div_ctrl_t  ctrl,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]     divisor,
    output logic [WIDTH-1:0]     quotient,
    output logic [WIDTH-1:0]     remainder,
    output pctd_pkg::div_stat_t  stat
);

    localparam int CNT_BITS = $clog2(WIDTH + 1);

    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [WIDTH-1:0]    rem_reg;
    logic [WIDTH-1:0]    rem_next;
    logic [WIDTH-1:0]    quo_reg;
    logic [WIDTH-1:0]    quo_next;

    logic [WIDTH:0]      shifted;
    logic [WIDTH:0]      diff;

    // The quotient register starts as the dividend; its top bit feeds the
    // partial remainder and the new quotient bit enters at the bottom.
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (ctrl.start)
        begin
            cnt_next  = CNT_BITS'(WIDTH);
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (diff[WIDTH])
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for prime_count_trial_division: directed table and random
// chunks, checked against a trial-division predictor.
// Depends on pctd_pkg and the prime_count_trial_division RTL.
`timescale 1ns / 1ps

module tb;

    import pctd_pkg::*;

    localparam int RANDOM_ITEMS   = 100;
    localparam int DRAIN_CYCLES   = 100;
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  chunk_end;
        logic                  fixed;
        result_t               want;
    } probe_t;

    localparam int PROBE_ROWS = 18;

    // Rows with fixed set carry an expectation read straight off the spec; the rest
    // are checked against the predictor.
    localparam probe_t PROBES [0:PROBE_ROWS-1] = '{
        '{32'd0,          1'b0, 1'b1, '{1'b0, 16'd0, 1'b0}},
        '{32'd1,          1'b0, 1'b1, '{1'b0, 16'd0, 1'b0}},
        '{32'd2,          1'b0, 1'b1, '{1'b1, 16'd1, 1'b0}},
        '{32'd3,          1'b0, 1'b1, '{1'b1, 16'd2, 1'b0}},
        '{32'd4,          1'b0, 1'b1, '{1'b0, 16'd2, 1'b0}},
        '{32'hFFFF_FFFF,  1'b1, 1'b1, '{1'b0, 16'd2, 1'b1}},
        '{32'hFFFF_FFFE,  1'b0, 1'b1, '{1'b0, 16'd0, 1'b0}},
        '{32'h8000_0000,  1'b0, 1'b1, '{1'b0, 16'd0, 1'b0}},
        '{32'd25,         1'b0, 1'b0, '0},
        '{32'd49,         1'b0, 1'b0, '0},
        '{32'd97,         1'b0, 1'b0, '0},
        '{32'd65521,      1'b0, 1'b0, '0},
        '{32'd65537,      1'b0, 1'b0, '0},
        '{32'd196563,     1'b0, 1'b0, '0},
        '{32'd1018081,    1'b0, 1'b0, '0},
        '{32'd1,          1'b1, 1'b0, '0},
        '{32'd2,          1'b1, 1'b1, '{1'b1, 16'd1, 1'b1}},
        '{32'd0,          1'b1, 1'b1, '{1'b0, 16'd0, 1'b1}}
    };

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    result_t                 pending_verdicts[$];
    logic [COUNT_BITS-1:0]   chunk_prime_tally;
    int                      failures;
    longint                  cycle_count;
    bit                      calm;
    int                      stall_left;

    prime_count_trial_division i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit trial_divide_prime(input logic [VALUE_BITS-1:0] v);
        longint unsigned n;
        longint unsigned d;
        n = v;
        if (n < 2)
            return 1'b0;
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the chunk tally exactly as the block does and returns the verdict.
    function automatic result_t predict_verdict(input item_t it);
        result_t r;
        bit      p;
        p = trial_divide_prime(it.value);
        if (p && chunk_prime_tally != COUNT_MAX)
            chunk_prime_tally = chunk_prime_tally + 1'b1;
        r.prime       = p;
        r.prime_count = chunk_prime_tally;
        r.count_final = it.chunk_end;
        if (it.chunk_end)
            chunk_prime_tally = '0;
        return r;
    endfunction

    function automatic int random_span();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return random_span();
    endfunction

    // Most values stay small so a prime costs few divisor trials; full-width values
    // are built to have a small factor.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned r;
        logic [VALUE_BITS-1:0] m;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(0, 255);
        if (r < 65)
            return $urandom_range(0, 65535);
        if (r < 75)
            return $urandom_range(0, 32'h0010_0000);
        if (r < 88)
            return $urandom & ~32'd1;
        m = ($urandom_range(0, 32'h2AAA_AAAA) << 1) | 32'd1;
        return m * 32'd3;
    endfunction

    task automatic send_item(input item_t it, input bit fixed, input result_t want);
        result_t verdict;
        int      gap;
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        verdict = predict_verdict(it);
        pending_verdicts.push_back(fixed ? want : verdict);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
            stall_left = random_span();
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_verdict
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result transaction with no input outstanding: %p", result);
                failures++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.prime !== want.prime)
                begin
                    $error("prime: expected %0d, got %0d", want.prime, result.prime);
                    failures++;
                end
                if (result.prime_count !== want.prime_count)
                begin
                    $error("prime_count: expected %0d, got %0d",
                           want.prime_count, result.prime_count);
                    failures++;
                end
                if (result.count_final !== want.count_final)
                begin
                    $error("count_final: expected %0d, got %0d",
                           want.count_final, result.count_final);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("prime_count_trial_division regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        item_t it;
        int    sent;
        int    chunk_len;
        bit    noisy;
        int    i;
        int    j;
        rst_n             = 1'b0;
        item_valid        = 1'b0;
        item              = '0;
        calm              = 1'b0;
        chunk_prime_tally = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PROBE_ROWS; i++)
        begin
            it.value     = PROBES[i].value;
            it.chunk_end = PROBES[i].chunk_end;
            send_item(it, PROBES[i].fixed, PROBES[i].want);
        end

        // Random chunks; a few have the chunk-end mark scattered at random.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            chunk_len = $urandom_range(1, 8);
            calm      = ($urandom_range(0, 3) == 0);
            noisy     = ($urandom_range(0, 4) == 0);
            for (j = 0; j < chunk_len; j++)
            begin
                it.value     = pick_value();
                it.chunk_end = noisy ? 1'($urandom_range(0, 1)) : (j == chunk_len - 1);
                send_item(it, 1'b0, '0);
                sent++;
            end
        end

        // Close any open chunk.
        calm = 1'b0;
        it.value     = 32'd0;
        it.chunk_end = 1'b1;
        send_item(it, 1'b0, '0);

        item_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("prime_count_trial_division regression: pass");
        else
            $display("prime_count_trial_division regression: fail");
        $finish;
    end

endmodule
